[hdl/sii_pkg.sv]
`timescale 1ns / 1ps

package sii_pkg;

	// Field widths of one beat.
	localparam int COORD_W = 31;
	localparam int COEF_W = 32;
	localparam int MARGIN_W = 15;

	// Width of a coordinate difference and of a coefficient difference.
	localparam int DIFF_W = COORD_W + 1;
	localparam int EDIFF_W = COEF_W + 1;

	// Cross products and their difference.
	localparam int PROD_W = 2 * DIFF_W;
	localparam int NUM_W = PROD_W + 1;

	// Register reset value and default fraction width.
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 15'd655;
	localparam int FRAC_BITS_DEF = 16;

	// Beat widths on the two streams.
	localparam int IN_TDATA_W = 376;
	localparam int OUT_TDATA_W = 128;

endpackage

[hdl/segment_intersect_interpolate.sv]
`timescale 1ns / 1ps

// Segment crossing test with interpolation along segment B. One beat enters
// per clock unless the output stream stalls, and one result beat leaves per
// beat taken, in order. Two restoring dividers produce one quotient bit per
// pipeline stage for ua and ub. A stall on the output stream holds the whole
// pipeline, and s_axis_tready follows it. A result with hit low carries
// all-zero data. edge_margin is to be written through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
module segment_intersect_interpolate #(
	parameter int FRAC_BITS = sii_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [sii_pkg::MARGIN_W-1:0] cfg_wr_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// a_start_x, a_start_z, a_end_x, a_end_z, b_start_x, b_start_z, b_end_x,
	// b_end_z (31 bits each), b_start_coef_one, b_start_coef_two,
	// b_end_coef_one, b_end_coef_two (32 bits each)
	input  logic [sii_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit_x, hit_z, hit_coef_one, hit_coef_two (32 bits each)
	output logic [sii_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// hit
	output logic m_axis_tuser
);

	localparam int DW = sii_pkg::DIFF_W;
	localparam int EW = sii_pkg::EDIFF_W;
	localparam int NW = sii_pkg::NUM_W;
	localparam int QW = FRAC_BITS;
	localparam int PW = EW + QW + 1;
	localparam int TW = EW + 1;
	localparam int VW = EW + 2;
	localparam int MW = ((QW > sii_pkg::MARGIN_W) ? QW : sii_pkg::MARGIN_W) + 1;
	localparam logic [MW-1:0] ONE_Q = MW'(1) << QW;
	localparam logic signed [PW-1:0] RND = PW'((1 << QW) - 1);
	localparam logic signed [VW-1:0] SAT_HI = VW'(64'sh7FFF_FFFF);
	localparam logic signed [VW-1:0] SAT_LO = -VW'(64'sh8000_0000);

	logic [sii_pkg::MARGIN_W-1:0] margin_q;
	logic adv;

	// Margin register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= sii_pkg::MARGIN_RST;
		end else if (cfg_wr_en) begin
			margin_q <= cfg_wr_data;
		end
	end

	// Input fields.
	logic signed [sii_pkg::COORD_W-1:0] ax, az, bx, bz, cx, cz, dx, dz;
	logic signed [sii_pkg::COEF_W-1:0] c1s, c2s, c1e, c2e;
	assign ax = s_axis_tdata[30:0];
	assign az = s_axis_tdata[61:31];
	assign bx = s_axis_tdata[92:62];
	assign bz = s_axis_tdata[123:93];
	assign cx = s_axis_tdata[154:124];
	assign cz = s_axis_tdata[185:155];
	assign dx = s_axis_tdata[216:186];
	assign dz = s_axis_tdata[247:217];
	assign c1s = s_axis_tdata[279:248];
	assign c2s = s_axis_tdata[311:280];
	assign c1e = s_axis_tdata[343:312];
	assign c2e = s_axis_tdata[375:344];

	// The whole pipeline moves unless the output register is full and held.
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Payload carried to the interpolation: start values and differences.
	typedef struct packed {
		logic signed [EW-1:0] s_x;
		logic signed [EW-1:0] s_z;
		logic signed [EW-1:0] s_1;
		logic signed [EW-1:0] s_2;
		logic signed [EW-1:0] d_x;
		logic signed [EW-1:0] d_z;
		logic signed [EW-1:0] d_1;
		logic signed [EW-1:0] d_2;
	} lerp_t;

	// Stage 1: coordinate differences.
	logic vld_s1;
	logic signed [DW-1:0] azc_s1, axc_s1, dxc_s1, dzc_s1, bxa_s1, bza_s1;
	lerp_t lp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			azc_s1 <= DW'(az) - DW'(cz);
			axc_s1 <= DW'(ax) - DW'(cx);
			dxc_s1 <= DW'(dx) - DW'(cx);
			dzc_s1 <= DW'(dz) - DW'(cz);
			bxa_s1 <= DW'(bx) - DW'(ax);
			bza_s1 <= DW'(bz) - DW'(az);
			lp_s1.s_x <= EW'(cx);
			lp_s1.s_z <= EW'(cz);
			lp_s1.s_1 <= EW'(c1s);
			lp_s1.s_2 <= EW'(c2s);
			lp_s1.d_x <= EW'(dx) - EW'(cx);
			lp_s1.d_z <= EW'(dz) - EW'(cz);
			lp_s1.d_1 <= EW'(c1e) - EW'(c1s);
			lp_s1.d_2 <= EW'(c2e) - EW'(c2s);
		end
	end

	// Stage 2: the six cross products.
	logic vld_s2;
	logic signed [sii_pkg::PROD_W-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	lerp_t lp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s2 <= azc_s1 * dxc_s1;
			p1_s2 <= axc_s1 * dzc_s1;
			p2_s2 <= azc_s1 * bxa_s1;
			p3_s2 <= axc_s1 * bza_s1;
			p4_s2 <= bxa_s1 * dzc_s1;
			p5_s2 <= bza_s1 * dxc_s1;
			lp_s2 <= lp_s1;
		end
	end

	// Stage 3: numerators and denominator.
	logic vld_s3;
	logic signed [NW-1:0] na_s3, nb_s3, dn_s3;
	lerp_t lp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s3 <= NW'(p0_s2) - NW'(p1_s2);
			nb_s3 <= NW'(p2_s2) - NW'(p3_s2);
			dn_s3 <= NW'(p4_s2) - NW'(p5_s2);
			lp_s3 <= lp_s2;
		end
	end

	// Stage 4: make the denominator positive.
	logic vld_s4;
	logic signed [NW-1:0] na_s4, nb_s4, dn_s4;
	lerp_t lp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s4 <= dn_s3[NW-1] ? -na_s3 : na_s3;
			nb_s4 <= dn_s3[NW-1] ? -nb_s3 : nb_s3;
			dn_s4 <= dn_s3[NW-1] ? -dn_s3 : dn_s3;
			lp_s4 <= lp_s3;
		end
	end

	// Stage 5: both parameters must lie strictly inside (0, 1).
	logic vld_s5, ok_s5;
	logic [NW-2:0] na_s5, nb_s5, dn_s5;
	lerp_t lp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s5 <= (dn_s4 != '0) && (na_s4 > 0) && (na_s4 < dn_s4)
				&& (nb_s4 > 0) && (nb_s4 < dn_s4);
			na_s5 <= na_s4[NW-2:0];
			nb_s5 <= nb_s4[NW-2:0];
			dn_s5 <= dn_s4[NW-2:0];
			lp_s5 <= lp_s4;
		end
	end

	// Stage 6: two restoring dividers, one quotient bit per stage.
	logic vld_s6 [QW];
	logic ok_s6 [QW];
	logic [NW-2:0] ra_s6 [QW];
	logic [NW-2:0] rb_s6 [QW];
	logic [NW-2:0] dn_s6 [QW];
	logic [QW-1:0] qa_s6 [QW];
	logic [QW-1:0] qb_s6 [QW];
	lerp_t lp_s6 [QW];

	logic [NW-2:0] ra_in [QW];
	logic [NW-2:0] rb_in [QW];
	logic [NW-2:0] dn_in [QW];
	logic [QW-1:0] qa_in [QW];
	logic [QW-1:0] qb_in [QW];

	always_comb begin
		ra_in[0] = na_s5;
		rb_in[0] = nb_s5;
		dn_in[0] = dn_s5;
		qa_in[0] = '0;
		qb_in[0] = '0;
		for (int k = 1; k < QW; k++) begin
			ra_in[k] = ra_s6[k-1];
			rb_in[k] = rb_s6[k-1];
			dn_in[k] = dn_s6[k-1];
			qa_in[k] = qa_s6[k-1];
			qb_in[k] = qb_s6[k-1];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW-1:0] ra_sh, rb_sh;
		logic ga, gb;

		assign ra_sh = {ra_in[k], 1'b0};
		assign rb_sh = {rb_in[k], 1'b0};
		assign ga = ra_sh >= {1'b0, dn_in[k]};
		assign gb = rb_sh >= {1'b0, dn_in[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[k] <= 1'b0;
			end else if (adv) begin
				vld_s6[k] <= (k == 0) ? vld_s5 : vld_s6[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ra_s6[k] <= ga ? (NW-1)'(ra_sh - {1'b0, dn_in[k]}) : (NW-1)'(ra_sh);
				rb_s6[k] <= gb ? (NW-1)'(rb_sh - {1'b0, dn_in[k]}) : (NW-1)'(rb_sh);
				qa_s6[k] <= {qa_in[k][QW-2:0], ga};
				qb_s6[k] <= {qb_in[k][QW-2:0], gb};
				dn_s6[k] <= dn_in[k];
				ok_s6[k] <= (k == 0) ? ok_s5 : ok_s6[(k == 0) ? 0 : k-1];
				lp_s6[k] <= (k == 0) ? lp_s5 : lp_s6[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Stage 7: margin test and the four interpolation products.
	logic vld_s7, hit_s7;
	logic signed [PW-1:0] px_s7, pz_s7, p1_s7, p2_s7;
	lerp_t lp_s7;
	logic [QW-1:0] ua, ub;
	logic signed [QW:0] ubs;
	lerp_t lp_d;
	logic in_margin;

	assign ua = qa_s6[QW-1];
	assign ub = qb_s6[QW-1];
	assign ubs = $signed({1'b0, ub});
	assign lp_d = lp_s6[QW-1];
	assign in_margin = (MW'(ua) > MW'(margin_q)) && (MW'(ua) + MW'(margin_q) < ONE_Q)
		&& (MW'(ub) > MW'(margin_q)) && (MW'(ub) + MW'(margin_q) < ONE_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s7 <= ok_s6[QW-1] && in_margin;
			px_s7 <= lp_d.d_x * ubs;
			pz_s7 <= lp_d.d_z * ubs;
			p1_s7 <= lp_d.d_1 * ubs;
			p2_s7 <= lp_d.d_2 * ubs;
			lp_s7 <= lp_d;
		end
	end

	// Stage 8: scale the products down, rounding toward zero.
	logic vld_s8, hit_s8;
	logic signed [TW-1:0] tx_s8, tz_s8, t1_s8, t2_s8;
	lerp_t lp_s8;

	function automatic logic signed [TW-1:0] trunc_q(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] b;
		b = p + (p[PW-1] ? RND : '0);
		return TW'(b >>> QW);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s8 <= hit_s7;
			tx_s8 <= trunc_q(px_s7);
			tz_s8 <= trunc_q(pz_s7);
			t1_s8 <= trunc_q(p1_s7);
			t2_s8 <= trunc_q(p2_s7);
			lp_s8 <= lp_s7;
		end
	end

	// Stage 9: add the start value, saturate, and zero a miss.
	logic vld_s9, hit_s9;
	logic [sii_pkg::COEF_W-1:0] vx_s9, vz_s9, v1_s9, v2_s9;

	function automatic logic [sii_pkg::COEF_W-1:0] add_sat(
		input logic signed [EW-1:0] s,
		input logic signed [TW-1:0] t,
		input logic h
	);
		logic signed [VW-1:0] v;
		v = VW'(s) + VW'(t);
		if (!h) begin
			return '0;
		end else if (v > SAT_HI) begin
			return SAT_HI[sii_pkg::COEF_W-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[sii_pkg::COEF_W-1:0];
		end
		return v[sii_pkg::COEF_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s9 <= hit_s8;
			vx_s9 <= add_sat(lp_s8.s_x, tx_s8, hit_s8);
			vz_s9 <= add_sat(lp_s8.s_z, tz_s8, hit_s8);
			v1_s9 <= add_sat(lp_s8.s_1, t1_s8, hit_s8);
			v2_s9 <= add_sat(lp_s8.s_2, t2_s8, hit_s8);
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tuser = hit_s9;
	assign m_axis_tdata = {v2_s9, v1_s9, vz_s9, vx_s9};

endmodule

[hdl/sii_chk.sv]
`timescale 1ns / 1ps

module sii_chk (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [sii_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic m_axis_tuser
);

	// A held result beat stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser)))
		else $error("held result beat changed");

	// A miss carries all-zero data.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("miss with nonzero data");

	// Input is taken exactly when the output is free to move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	// Nothing comes out right after reset.
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result beat right after reset");

endmodule

bind segment_intersect_interpolate sii_chk u_sii_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

[dv/segment_intersect_interpolate_tb.sv]
`timescale 1ns / 1ps

module segment_intersect_interpolate_tb;

	localparam int FRAC = sii_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MW = sii_pkg::MARGIN_W;
	localparam int CW = sii_pkg::COORD_W;
	localparam int KW = sii_pkg::COEF_W;
	localparam logic [MW-1:0] MARGIN_MAX = '1;

	// One input beat, fields named after their roles in the geometry.
	typedef struct {
		logic signed [CW-1:0] asx, asz, aex, aez, bsx, bsz, bex, bez;
		logic signed [KW-1:0] k1s, k2s, k1e, k2e;
	} seg_pair_t;

	// One result beat.
	typedef struct {
		logic hit;
		logic [KW-1:0] x, z, k1, k2;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [MW-1:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [sii_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [sii_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	logic [MW-1:0] margin_now = sii_pkg::MARGIN_RST;
	crossing_t pending_crossings[$];
	int unsigned mismatches = 0;
	int unsigned hits_seen = 0;
	int unsigned beats_seen = 0;
	int unsigned cycles = 0;
	bit no_idle = 1'b0;

	segment_intersect_interpolate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Restoring division: floor(num * 2^FRAC / den) for 0 <= num < den.
	function automatic logic [63:0] fraction_of(logic [63:0] num, logic [63:0] den);
		logic [63:0] r;
		logic [63:0] q;
		r = num;
		q = '0;
		for (int i = 0; i < FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// Point between s and e at fraction q, truncated toward zero and saturated.
	function automatic logic [31:0] lerp_at(longint s, longint e, longint q);
		longint p;
		longint t;
		longint v;
		p = (e - s) * q;
		t = (p >= 0) ? (p >>> FRAC) : -((-p) >>> FRAC);
		v = s + t;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	// Expected result for one pair under the given margin.
	function automatic crossing_t predict_crossing(seg_pair_t p, logic [MW-1:0] m);
		crossing_t r;
		longint ax, az, bx, bz, cx, cz, dx, dz;
		longint na, nb, dn, lo, hi;
		longint ua, ub;
		r = '{hit: 1'b0, x: '0, z: '0, k1: '0, k2: '0};
		ax = p.asx; az = p.asz; bx = p.aex; bz = p.aez;
		cx = p.bsx; cz = p.bsz; dx = p.bex; dz = p.bez;
		na = (az - cz) * (dx - cx) - (ax - cx) * (dz - cz);
		nb = (az - cz) * (bx - ax) - (ax - cx) * (bz - az);
		dn = (bx - ax) * (dz - cz) - (bz - az) * (dx - cx);
		if (dn == 0) return r;
		if (dn < 0) begin
			na = -na;
			nb = -nb;
			dn = -dn;
		end
		if (na <= 0 || na >= dn || nb <= 0 || nb >= dn) return r;
		ua = longint'(fraction_of(na, dn));
		ub = longint'(fraction_of(nb, dn));
		lo = longint'(m);
		hi = (64'sd1 << FRAC) - lo;
		if (!(ua > lo && ua < hi && ub > lo && ub < hi)) return r;
		r.hit = 1'b1;
		r.x = lerp_at(cx, dx, ub);
		r.z = lerp_at(cz, dz, ub);
		r.k1 = lerp_at(p.k1s, p.k1e, ub);
		r.k2 = lerp_at(p.k2s, p.k2e, ub);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("Mismatch on result %0d: %s got %h expected %h", beats_seen, what, got,
			want);
		mismatches++;
	endtask

	// Result side: random stalls and a field-by-field check of every beat.
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 26);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_crossings.size() == 0) begin
					$display("Result beat %0d arrived with nothing expected", beats_seen);
					mismatches++;
				end else begin
					want = pending_crossings.pop_front();
					if (m_axis_tuser !== want.hit)
						report_mismatch("hit", 32'(m_axis_tuser), 32'(want.hit));
					if (m_axis_tdata[31:0] !== want.x)
						report_mismatch("hit_x", m_axis_tdata[31:0], want.x);
					if (m_axis_tdata[63:32] !== want.z)
						report_mismatch("hit_z", m_axis_tdata[63:32], want.z);
					if (m_axis_tdata[95:64] !== want.k1)
						report_mismatch("hit_coef_one", m_axis_tdata[95:64], want.k1);
					if (m_axis_tdata[127:96] !== want.k2)
						report_mismatch("hit_coef_two", m_axis_tdata[127:96], want.k2);
					if (want.hit) hits_seen++;
				end
				beats_seen++;
			end
		end
	end

	// Send one pair, with an optional random gap first; tvalid stays high on return.
	task automatic send_pair(seg_pair_t p);
		while (!no_idle && $urandom_range(0, 99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.k2e, p.k1e, p.k2s, p.k1s, p.bez, p.bex, p.bsz, p.bsx,
			p.aez, p.aex, p.asz, p.asx};
		do @(posedge clk); while (!s_axis_tready);
		pending_crossings.push_back(predict_crossing(p, margin_now));
	endtask

	// Stop sending and wait until every result has come, then let the pipe settle.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_margin(logic [MW-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		margin_now = value;
	endtask

	function automatic seg_pair_t make_pair(longint v[8]);
		seg_pair_t p;
		p.asx = CW'(v[0]); p.asz = CW'(v[1]); p.aex = CW'(v[2]); p.aez = CW'(v[3]);
		p.bsx = CW'(v[4]); p.bsz = CW'(v[5]); p.bex = CW'(v[6]); p.bez = CW'(v[7]);
		p.k1s = $urandom; p.k2s = $urandom; p.k1e = $urandom; p.k2e = $urandom;
		return p;
	endfunction

	// Four endpoints in a box of random size; a fair share of them cross.
	function automatic seg_pair_t boxed_pair();
		longint v[8];
		int unsigned span;
		span = $urandom_range(2, 30);
		for (int i = 0; i < 8; i++)
			v[i] = longint'($urandom_range(0, (32'd1 << (span + 1)) - 1)) -
				(64'sd1 << span);
		return make_pair(v);
	endfunction

	// Raw bit patterns in every field.
	function automatic seg_pair_t noise_pair();
		longint v[8];
		for (int i = 0; i < 8; i++) v[i] = longint'($signed(31'($urandom)));
		return make_pair(v);
	endfunction

	// Edge cases: extremes, parallel, touching ends, crossings near the margin.
	task automatic test_directed();
		seg_pair_t p;
		longint lim = 64'sd1073741823;
		longint v[8];
		v = '{-lim - 1, -lim - 1, lim, lim, -lim - 1, lim, lim, -lim - 1};
		p = make_pair(v);
		p.k1s = 32'h8000_0000; p.k1e = 32'h7fff_ffff;
		p.k2s = 32'h7fff_ffff; p.k2e = 32'h8000_0000;
		send_pair(p);
		v = '{lim, -lim - 1, -lim - 1, lim, -lim - 1, -lim - 1, lim, lim};
		send_pair(make_pair(v));
		v = '{0, 0, 0, 0, 0, 0, 0, 0};
		send_pair(make_pair(v));
		v = '{lim, lim, lim, lim, -lim - 1, -lim - 1, -lim - 1, -lim - 1};
		send_pair(make_pair(v));
		// Parallel and coincident segments.
		v = '{0, 0, 65536, 0, 0, 65536, 65536, 65536};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 0, 0, 65536, 0};
		send_pair(make_pair(v));
		// A crossing at the middle, touching at an endpoint, and crossing just outside [0,1].
		v = '{0, 0, 65536, 65536, 0, 65536, 65536, 0};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 0, -65536, 0, 65536};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 70000, -65536, 70000, 65536};
		send_pair(make_pair(v));
		// Crossings close to the margin on either side.
		v = '{0, 0, 65536, 0, 654, -65536, 654, 65536};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 656, -65536, 656, 65536};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 64880, -65536, 64882, 65536};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 32768, -100, 32768, 65436};
		send_pair(make_pair(v));
		v = '{0, 0, 65536, 0, 32768, -65500, 32768, 36};
		send_pair(make_pair(v));
		v = '{-lim - 1, 0, lim, 0, 0, -lim - 1, 0, lim};
		send_pair(make_pair(v));
		v = '{-lim - 1, 0, lim, 0, 5, -lim - 1, -7, lim};
		send_pair(make_pair(v));
		for (int i = 0; i < 4; i++) send_pair(noise_pair());
		drain_results();
	endtask

	task automatic test_random_pairs(int count, bit quiet);
		no_idle = quiet;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) send_pair(noise_pair());
			else send_pair(boxed_pair());
		end
		drain_results();
		no_idle = 1'b0;
	endtask

	task automatic test_margins();
		write_margin('0);
		test_random_pairs(150, 1'b0);
		write_margin(MARGIN_MAX);
		test_random_pairs(60, 1'b0);
		write_margin(MW'(32767 / 2));
		test_random_pairs(60, 1'b0);
		write_margin(MW'($urandom_range(0, 32767)));
		test_random_pairs(80, 1'b0);
		write_margin(MW'($urandom_range(0, 2000)));
		test_random_pairs(120, 1'b0);
		write_margin(sii_pkg::MARGIN_RST);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_pairs(250, 1'b0);
		test_random_pairs(150, 1'b1);
		test_margins();
		$display("Covered directed edge cases, %0d result beats (%0d hits) over several margins.",
			beats_seen, hits_seen);
		if (mismatches == 0 && pending_crossings.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
